### sv/aging_linear_probe_hash_table_assert.svh
// Assertion macros for the aging linear probe hash table.
// Expects clock aclk and synchronous active-low reset aresetn in the including scope.
`ifndef AGING_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define AGING_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define ALPHT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("invariant violated");

// When the trigger holds, the consequence holds in the next cycle.
`define ALPHT_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("sequence violated");

`endif

### sv/alpht_pkg.sv
// Shared types and constants of the aging linear probe hash table.
// No dependencies.
package alpht_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FORGET = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_HIT       = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_NULL      = 3'd2,
        STAT_REMOVED   = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_DONE      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_SCAN,
        ST_CLEAR,
        ST_RE_RD,
        ST_RE_LATCH,
        ST_AFTER_SWEEP,
        ST_FINISH
    } fsm_state_t;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_LOOKUP,
        OP_ROOM1,
        OP_ROOM2,
        OP_TICK,
        OP_FORGET,
        OP_CLEARALL
    } op_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_index;
        logic [10:0] entry_count;
        logic        was_cleared;
    } out_item_t;

    localparam logic [1:0] CFG_IDLE_FRAMES = 2'd0;
    localparam logic [1:0] CFG_LOAD_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_PERIOD_LOG2 = 2'd2;

    localparam logic [15:0] IDLE_FRAMES_RST = 16'd90;
    localparam logic [9:0]  LOAD_LIMIT_RST  = 10'(1024 * 7 / 10);
    localparam logic [4:0]  PERIOD_LOG2_RST = 5'd6;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

endpackage

### sv/aging_linear_probe_hash_table.sv
// Channel   Ports                 Payload            Direction
// input     s_valid/s_ready       s_data (in_item_t)  in
// result    m_valid/m_ready       m_data (out_item_t) out
// config    psel..pready (APB)    3 registers         in/out
// A lookup that needs no room, or a forget of an absent key, runs the byte-serial hash and then
// one registered table read per probed slot before the next input transfer is taken. A sweep
// scans every slot; when it removes entries it clears the table and reinserts each survivor.
// After reset a clearing pass runs before the first transfer is taken. A result waiting for
// m_ready holds the next item in its last cycle.
// Top level of the aging hash table; depends on alpht_pkg, alpht_ram, alpht_hash and the
// assertion header.
`include "aging_linear_probe_hash_table_assert.svh"

module aging_linear_probe_hash_table #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  alpht_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output alpht_pkg::out_item_t  m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDXW = $clog2(TABLE_SLOTS);
    localparam int CW   = IDXW + 1;
    localparam int EW   = KEY_BITS + 32;
    localparam int CMPW = (CW > 10) ? CW : 10;

    alpht_pkg::fsm_state_t state_reg, state_next;
    alpht_pkg::op_t        op_reg;
    alpht_pkg::status_t    status_reg;

    logic [KEY_BITS-1:0] key_reg;
    logic [31:0]         frame_reg;
    logic [CW-1:0]       count_reg;
    logic [15:0]         idle_reg;
    logic [9:0]          limit_reg;
    logic [4:0]          period_reg;
    logic                cleared_reg;
    logic [IDXW-1:0]     slot_reg;
    logic [IDXW-1:0]     probe_addr_reg;
    logic [IDXW-1:0]     probe_cnt_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic                chk_vld_reg;
    logic [IDXW-1:0]     chk_idx_reg;
    logic [31:0]         age_limit_reg;
    logic                excl_vld_reg;
    logic [IDXW-1:0]     excl_idx_reg;
    logic [CW-1:0]       keep_n_reg;
    logic                removed_reg;
    logic [IDXW-1:0]     clr_idx_reg;
    logic [CW-1:0]       re_idx_reg;
    logic [EW-1:0]       re_entry_reg;
    logic                rebuild_reg;
    logic                m_valid_reg;
    alpht_pkg::out_item_t m_data_reg;

    logic                main_we;
    logic [IDXW-1:0]     main_waddr;
    logic [EW-1:0]       main_wdata;
    logic [IDXW-1:0]     main_raddr;
    logic [EW-1:0]       main_rdata;
    logic                keep_we;
    logic [EW-1:0]       keep_rdata;
    logic                hash_start;
    logic [KEY_BITS-1:0] hash_key;
    logic                hash_done;
    logic [31:0]         hash_val;

    logic [KEY_BITS-1:0] s_key;
    logic                s_null;
    logic                acc;
    logic                room_needed;
    logic [KEY_BITS-1:0] main_key;
    logic [31:0]         main_seen;
    logic                main_empty;
    logic                probe_hit;
    logic                probe_last;
    logic [IDXW-1:0]     probe_addr_inc;
    logic                scan_drop;
    logic                scan_end;
    logic                clr_last;
    logic                re_done;
    logic                out_free;
    logic [31:0]         frame_inc;
    logic [31:0]         tick_mask;
    logic                tick_sweep;
    logic                idle_hash;
    logic                go_lookup;
    logic                cfg_we;

    assign s_key       = s_data.key[KEY_BITS-1:0];
    assign s_null      = (s_key == '0);
    assign s_ready     = (state_reg == alpht_pkg::ST_IDLE);
    assign acc         = s_valid && s_ready;
    assign room_needed = CMPW'(count_reg) >= CMPW'(limit_reg);
    assign main_key    = main_rdata[EW-1:32];
    assign main_seen   = main_rdata[31:0];
    assign main_empty  = (main_key == '0);
    assign probe_hit   = main_empty || (!rebuild_reg && main_key == key_reg);
    assign probe_last  = (probe_cnt_reg == '1);
    assign probe_addr_inc = IDXW'(probe_addr_reg + 1'b1);
    assign scan_drop   = !main_empty && (excl_vld_reg ? (chk_idx_reg == excl_idx_reg)
                                                      : ((frame_reg - main_seen) > age_limit_reg));
    assign scan_end    = scan_idx_reg[IDXW] && !chk_vld_reg;
    assign clr_last    = (clr_idx_reg == '1);
    assign re_done     = (re_idx_reg == keep_n_reg);
    assign out_free    = !m_valid_reg || m_ready;
    assign frame_inc   = frame_reg + 32'd1;
    assign tick_mask   = (32'd1 << period_reg) - 32'd1;
    assign tick_sweep  = ((frame_inc & tick_mask) == 32'd0);
    assign idle_hash   = acc && !s_null && ((s_data.cmd == alpht_pkg::CMD_LOOKUP && !room_needed)
                                            || s_data.cmd == alpht_pkg::CMD_FORGET);
    assign go_lookup   = (op_reg == alpht_pkg::OP_ROOM1 || op_reg == alpht_pkg::OP_ROOM2)
                         && !room_needed;
    assign cfg_we      = psel && penable && pwrite;

    alpht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    alpht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_keep_ram (
        .aclk  (aclk),
        .we    (keep_we),
        .waddr (keep_n_reg[IDXW-1:0]),
        .wdata (main_rdata),
        .raddr (re_idx_reg[IDXW-1:0]),
        .rdata (keep_rdata)
    );

    alpht_hash #(.KEY_BITS(KEY_BITS)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key_in  (hash_key),
        .done    (hash_done),
        .hash    (hash_val)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            alpht_pkg::ST_IDLE: begin
                if (acc) begin
                    if (s_data.cmd == alpht_pkg::CMD_CLEAR) begin
                        state_next = alpht_pkg::ST_CLEAR;
                    end else if (s_data.cmd == alpht_pkg::CMD_TICK) begin
                        state_next = tick_sweep ? alpht_pkg::ST_SCAN : alpht_pkg::ST_FINISH;
                    end else if (s_null) begin
                        state_next = alpht_pkg::ST_FINISH;
                    end else if (idle_hash) begin
                        state_next = alpht_pkg::ST_HASH;
                    end else begin
                        state_next = alpht_pkg::ST_SCAN;
                    end
                end
            end
            alpht_pkg::ST_HASH: begin
                if (hash_done) begin
                    state_next = alpht_pkg::ST_PROBE_RD;
                end
            end
            alpht_pkg::ST_PROBE_RD: state_next = alpht_pkg::ST_PROBE_CHK;
            alpht_pkg::ST_PROBE_CHK: begin
                if (probe_hit || probe_last) begin
                    if (rebuild_reg) begin
                        state_next = alpht_pkg::ST_RE_RD;
                    end else if (op_reg == alpht_pkg::OP_FORGET && probe_hit && !main_empty) begin
                        state_next = alpht_pkg::ST_SCAN;
                    end else begin
                        state_next = alpht_pkg::ST_FINISH;
                    end
                end
            end
            alpht_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = removed_reg ? alpht_pkg::ST_CLEAR : alpht_pkg::ST_AFTER_SWEEP;
                end
            end
            alpht_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    if (rebuild_reg) begin
                        state_next = alpht_pkg::ST_RE_RD;
                    end else if (op_reg == alpht_pkg::OP_INIT) begin
                        state_next = alpht_pkg::ST_IDLE;
                    end else if (op_reg == alpht_pkg::OP_ROOM2) begin
                        state_next = alpht_pkg::ST_HASH;
                    end else begin
                        state_next = alpht_pkg::ST_FINISH;
                    end
                end
            end
            alpht_pkg::ST_RE_RD: begin
                state_next = re_done ? alpht_pkg::ST_AFTER_SWEEP : alpht_pkg::ST_RE_LATCH;
            end
            alpht_pkg::ST_RE_LATCH: state_next = alpht_pkg::ST_HASH;
            alpht_pkg::ST_AFTER_SWEEP: begin
                if (go_lookup) begin
                    state_next = alpht_pkg::ST_HASH;
                end else if (op_reg == alpht_pkg::OP_ROOM1) begin
                    state_next = alpht_pkg::ST_SCAN;
                end else if (op_reg == alpht_pkg::OP_ROOM2) begin
                    state_next = alpht_pkg::ST_CLEAR;
                end else begin
                    state_next = alpht_pkg::ST_FINISH;
                end
            end
            alpht_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = alpht_pkg::ST_IDLE;
                end
            end
            default: state_next = alpht_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        main_we    = 1'b0;
        main_waddr = probe_addr_reg;
        main_wdata = {key_reg, frame_reg};
        main_raddr = probe_addr_reg;
        keep_we    = 1'b0;
        hash_start = 1'b0;
        hash_key   = key_reg;
        unique case (state_reg)
            alpht_pkg::ST_IDLE: begin
                hash_start = idle_hash;
                hash_key   = s_key;
            end
            alpht_pkg::ST_PROBE_CHK: begin
                main_raddr = probe_addr_inc;
                if (rebuild_reg) begin
                    main_we    = probe_hit;
                    main_wdata = re_entry_reg;
                end else if (op_reg != alpht_pkg::OP_FORGET) begin
                    main_we = probe_hit;
                end
            end
            alpht_pkg::ST_SCAN: begin
                main_raddr = scan_idx_reg[IDXW-1:0];
                keep_we    = chk_vld_reg && !main_empty && !scan_drop;
            end
            alpht_pkg::ST_CLEAR: begin
                main_we    = 1'b1;
                main_waddr = clr_idx_reg;
                main_wdata = '0;
                hash_start = clr_last && !rebuild_reg && op_reg == alpht_pkg::OP_ROOM2;
            end
            alpht_pkg::ST_RE_LATCH: begin
                hash_start = 1'b1;
                hash_key   = keep_rdata[EW-1:32];
            end
            alpht_pkg::ST_AFTER_SWEEP: begin
                hash_start = go_lookup;
            end
            default: begin
                hash_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= alpht_pkg::ST_CLEAR;
            op_reg      <= alpht_pkg::OP_INIT;
            rebuild_reg <= 1'b0;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            frame_reg   <= '0;
            idle_reg    <= alpht_pkg::IDLE_FRAMES_RST;
            limit_reg   <= alpht_pkg::LOAD_LIMIT_RST;
            period_reg  <= alpht_pkg::PERIOD_LOG2_RST;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (paddr[3:2])
                    alpht_pkg::CFG_IDLE_FRAMES: idle_reg   <= pwdata[15:0];
                    alpht_pkg::CFG_LOAD_LIMIT:  limit_reg  <= pwdata[9:0];
                    alpht_pkg::CFG_PERIOD_LOG2: period_reg <= pwdata[4:0];
                    default: ;
                endcase
            end
            if (state_reg == alpht_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                alpht_pkg::ST_IDLE: begin
                    if (acc) begin
                        excl_vld_reg    <= 1'b0;
                        age_limit_reg   <= {16'd0, idle_reg};
                        scan_idx_reg    <= '0;
                        chk_vld_reg     <= 1'b0;
                        keep_n_reg      <= '0;
                        removed_reg     <= 1'b0;
                        clr_idx_reg     <= '0;
                        unique case (alpht_pkg::cmd_t'(s_data.cmd))
                            alpht_pkg::CMD_LOOKUP: begin
                                op_reg <= room_needed ? alpht_pkg::OP_ROOM1
                                                      : alpht_pkg::OP_LOOKUP;
                            end
                            alpht_pkg::CMD_TICK: begin
                                op_reg    <= alpht_pkg::OP_TICK;
                                frame_reg <= frame_inc;
                            end
                            alpht_pkg::CMD_FORGET: op_reg <= alpht_pkg::OP_FORGET;
                            alpht_pkg::CMD_CLEAR:  op_reg <= alpht_pkg::OP_CLEARALL;
                        endcase
                    end
                end
                alpht_pkg::ST_PROBE_CHK: begin
                    if (probe_hit || probe_last) begin
                        if (rebuild_reg) begin
                            re_idx_reg <= CW'(re_idx_reg + 1'b1);
                        end else if (op_reg == alpht_pkg::OP_FORGET) begin
                            excl_vld_reg <= 1'b1;
                            scan_idx_reg <= '0;
                            chk_vld_reg  <= 1'b0;
                            keep_n_reg   <= '0;
                            removed_reg  <= 1'b0;
                            clr_idx_reg  <= '0;
                        end else if (probe_hit && main_empty) begin
                            count_reg <= CW'(count_reg + 1'b1);
                        end
                    end
                end
                alpht_pkg::ST_SCAN: begin
                    if (!scan_idx_reg[IDXW]) begin
                        scan_idx_reg <= CW'(scan_idx_reg + 1'b1);
                    end
                    chk_vld_reg <= !scan_idx_reg[IDXW];
                    if (chk_vld_reg) begin
                        if (scan_drop) begin
                            removed_reg <= 1'b1;
                        end else if (!main_empty) begin
                            keep_n_reg <= CW'(keep_n_reg + 1'b1);
                        end
                    end
                    if (scan_end && removed_reg) begin
                        rebuild_reg <= 1'b1;
                        clr_idx_reg <= '0;
                    end
                end
                alpht_pkg::ST_CLEAR: begin
                    clr_idx_reg <= IDXW'(clr_idx_reg + 1'b1);
                    if (clr_last) begin
                        re_idx_reg <= '0;
                        if (!rebuild_reg) begin
                            count_reg <= '0;
                            if (op_reg == alpht_pkg::OP_ROOM2) begin
                                op_reg <= alpht_pkg::OP_LOOKUP;
                            end
                        end
                    end
                end
                alpht_pkg::ST_RE_RD: begin
                    if (re_done) begin
                        count_reg   <= keep_n_reg;
                        rebuild_reg <= 1'b0;
                    end
                end
                alpht_pkg::ST_AFTER_SWEEP: begin
                    if (go_lookup) begin
                        op_reg <= alpht_pkg::OP_LOOKUP;
                    end else if (op_reg == alpht_pkg::OP_ROOM1) begin
                        op_reg          <= alpht_pkg::OP_ROOM2;
                        age_limit_reg   <= '0;
                        scan_idx_reg    <= '0;
                        chk_vld_reg     <= 1'b0;
                        keep_n_reg      <= '0;
                        removed_reg     <= 1'b0;
                    end else if (op_reg == alpht_pkg::OP_ROOM2) begin
                        clr_idx_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            alpht_pkg::ST_IDLE: begin
                key_reg     <= s_key;
                cleared_reg <= 1'b0;
                slot_reg    <= '0;
                if (s_data.cmd == alpht_pkg::CMD_TICK || s_data.cmd == alpht_pkg::CMD_CLEAR) begin
                    status_reg <= alpht_pkg::STAT_DONE;
                end else begin
                    status_reg <= s_null ? alpht_pkg::STAT_NULL : alpht_pkg::STAT_DONE;
                end
            end
            alpht_pkg::ST_HASH: begin
                probe_addr_reg <= hash_val[IDXW-1:0];
                probe_cnt_reg  <= '0;
            end
            alpht_pkg::ST_PROBE_CHK: begin
                if (!(probe_hit || probe_last)) begin
                    probe_addr_reg <= probe_addr_inc;
                    probe_cnt_reg  <= IDXW'(probe_cnt_reg + 1'b1);
                end else if (!rebuild_reg) begin
                    if (!probe_hit || (op_reg == alpht_pkg::OP_FORGET && main_empty)) begin
                        status_reg <= alpht_pkg::STAT_NOT_FOUND;
                    end else if (op_reg == alpht_pkg::OP_FORGET) begin
                        status_reg   <= alpht_pkg::STAT_REMOVED;
                        excl_idx_reg <= probe_addr_reg;
                    end else begin
                        status_reg <= main_empty ? alpht_pkg::STAT_INSERTED
                                                 : alpht_pkg::STAT_HIT;
                        slot_reg   <= probe_addr_reg;
                    end
                end
            end
            alpht_pkg::ST_SCAN: begin
                chk_idx_reg <= scan_idx_reg[IDXW-1:0];
            end
            alpht_pkg::ST_CLEAR: begin
                if (clr_last && !rebuild_reg && op_reg == alpht_pkg::OP_ROOM2) begin
                    cleared_reg <= 1'b1;
                end
            end
            alpht_pkg::ST_RE_LATCH: begin
                re_entry_reg <= keep_rdata;
            end
            alpht_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_data_reg.status      <= status_reg;
                    m_data_reg.slot_index  <= 10'(slot_reg);
                    m_data_reg.entry_count <= 11'(count_reg);
                    m_data_reg.was_cleared <= cleared_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (paddr[3:2])
            alpht_pkg::CFG_IDLE_FRAMES: prdata = {16'd0, idle_reg};
            alpht_pkg::CFG_LOAD_LIMIT:  prdata = {22'd0, limit_reg};
            alpht_pkg::CFG_PERIOD_LOG2: prdata = {27'd0, period_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign pready  = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ALPHT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_SLOTS))
    `ALPHT_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != alpht_pkg::ST_IDLE)
    `ALPHT_ASSERT_NEXT(a_finish_loads, state_reg == alpht_pkg::ST_FINISH && out_free, m_valid_reg && state_reg == alpht_pkg::ST_IDLE)

endmodule

### sv/alpht_ram.sv
// Simple dual-port synchronous RAM with registered read.
// No dependencies.
module alpht_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### sv/alpht_hash.sv
// Iterative FNV-1a hash, one key byte per cycle, least significant byte first.
// Depends on alpht_pkg.
module alpht_hash #(
    parameter int KEY_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [KEY_BITS-1:0] key_in,
    output logic                done,
    output logic [31:0]         hash
);

    localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
    localparam int CNT_W = $clog2(KEY_BYTES) + 1;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [31:0]            h_reg;
    logic [KEY_BYTES*8-1:0] key_reg;
    logic [31:0]            mix;
    logic [31:0]            h_next;

    assign mix    = h_reg ^ {24'd0, key_reg[7:0]};
    assign h_next = mix * alpht_pkg::FNV_PRIME;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CNT_W'(KEY_BYTES);
            h_reg   <= alpht_pkg::FNV_BASIS;
            key_reg <= (KEY_BYTES*8)'(key_in);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            h_reg   <= h_next;
            key_reg <= key_reg >> 8;
        end
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

### tb/aging_linear_probe_hash_table_tb.sv
// Self-checking testbench for the aging linear probe hash table.
// Drives lookup, tick, forget and clear transfers and checks results against an in-bench model.
// Depends on alpht_pkg and the aging_linear_probe_hash_table RTL.
module aging_linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 1024;
    localparam int WDOG_LIMIT = 200000;

    typedef struct {
        alpht_pkg::cmd_t      cmd;
        logic [63:0]          key;
        bit                   typed;
        alpht_pkg::out_item_t res;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    alpht_pkg::in_item_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    alpht_pkg::out_item_t m_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    aging_linear_probe_hash_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model of the table.
    bit [63:0] tbl_key [SLOTS];
    bit [31:0] tbl_seen [SLOTS];
    int        tbl_count;
    bit [31:0] frame_no;
    bit [15:0] idle_cfg;
    bit [9:0]  limit_cfg;
    bit [4:0]  period_log2;

    alpht_pkg::out_item_t expected_results[$];
    bit [63:0] key_pool[$];
    int        fails;
    int        sent;
    int        idle_mode;
    bit        hold_start;
    bit        hold_taken;
    int        hold_left;
    int        quiet_cycles;

    function automatic bit [31:0] fnv_hash(bit [63:0] k);
        bit [31:0] h;
        h = alpht_pkg::FNV_BASIS;
        for (int i = 0; i < 8; i++) begin
            h = (h ^ {24'd0, k[8*i +: 8]}) * alpht_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    function automatic int probe_slot(bit [63:0] k);
        int start;
        int at;
        start = int'(fnv_hash(k) & 32'(SLOTS - 1));
        for (int p = 0; p < SLOTS; p++) begin
            at = (start + p) & (SLOTS - 1);
            if (tbl_key[at] == 0 || tbl_key[at] == k) return at;
        end
        return -1;
    endfunction

    function automatic void rebuild_table();
        bit [63:0] kk[$];
        bit [31:0] ss[$];
        int        at;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_key[i] != 0) begin
                kk.push_back(tbl_key[i]);
                ss.push_back(tbl_seen[i]);
            end
            tbl_key[i] = 0;
        end
        tbl_count = 0;
        foreach (kk[i]) begin
            at = probe_slot(kk[i]);
            if (at >= 0) begin
                tbl_key[at] = kk[i];
                tbl_seen[at] = ss[i];
                tbl_count++;
            end
        end
    endfunction

    function automatic void sweep_idle(bit [31:0] max_age);
        bit removed;
        removed = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_key[i] != 0 && (frame_no - tbl_seen[i]) > max_age) begin
                tbl_key[i] = 0;
                tbl_count--;
                removed = 1;
            end
        end
        if (removed) rebuild_table();
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < SLOTS; i++) tbl_key[i] = 0;
        tbl_count = 0;
    endfunction

    function automatic alpht_pkg::out_item_t predict_result(alpht_pkg::in_item_t it);
        alpht_pkg::out_item_t r;
        int        at;
        bit [31:0] mask;
        r = '{status: alpht_pkg::STAT_DONE, slot_index: '0, entry_count: '0, was_cleared: 1'b0};
        case (alpht_pkg::cmd_t'(it.cmd))
            alpht_pkg::CMD_LOOKUP: begin
                if (it.key == 0) begin
                    r.status = alpht_pkg::STAT_NULL;
                end else begin
                    if (tbl_count >= limit_cfg) begin
                        sweep_idle(32'(idle_cfg));
                        if (tbl_count >= limit_cfg) sweep_idle(0);
                        if (tbl_count >= limit_cfg) begin
                            empty_table();
                            r.was_cleared = 1'b1;
                        end
                    end
                    at = probe_slot(it.key);
                    if (at < 0) begin
                        r.status = alpht_pkg::STAT_NOT_FOUND;
                    end else begin
                        if (tbl_key[at] == 0) begin
                            tbl_key[at] = it.key;
                            tbl_count++;
                            r.status = alpht_pkg::STAT_INSERTED;
                        end else begin
                            r.status = alpht_pkg::STAT_HIT;
                        end
                        tbl_seen[at] = frame_no;
                        r.slot_index = 10'(at);
                    end
                end
            end
            alpht_pkg::CMD_TICK: begin
                mask = (32'd1 << period_log2) - 32'd1;
                frame_no++;
                if ((frame_no & mask) == 0) sweep_idle(32'(idle_cfg));
            end
            alpht_pkg::CMD_FORGET: begin
                if (it.key == 0) begin
                    r.status = alpht_pkg::STAT_NULL;
                end else begin
                    at = probe_slot(it.key);
                    if (at >= 0 && tbl_key[at] != 0) begin
                        tbl_key[at] = 0;
                        tbl_count--;
                        rebuild_table();
                        r.status = alpht_pkg::STAT_REMOVED;
                    end else begin
                        r.status = alpht_pkg::STAT_NOT_FOUND;
                    end
                end
            end
            default: begin
                empty_table();
            end
        endcase
        r.entry_count = 11'(tbl_count);
        return r;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic cfg_write(logic [3:0] addr, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            4'(4 * alpht_pkg::CFG_IDLE_FRAMES): idle_cfg = val[15:0];
            4'(4 * alpht_pkg::CFG_LOAD_LIMIT):  limit_cfg = val[9:0];
            4'(4 * alpht_pkg::CFG_PERIOD_LOG2): period_log2 = val[4:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(alpht_pkg::in_item_t it, bit typed,
                             alpht_pkg::out_item_t typed_res);
        alpht_pkg::out_item_t pred;
        idle_mode = (sent / 50) % 4;
        while ((idle_mode == 1 && roll(64)) || (idle_mode == 3 && roll(12))) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        pred = predict_result(it);
        expected_results.push_back(typed ? typed_res : pred);
        sent++;
        @(negedge aclk);
    endtask

    function automatic alpht_pkg::in_item_t random_item();
        alpht_pkg::in_item_t it;
        int       r;
        r = $urandom_range(99);
        it.cmd = (r < 70) ? alpht_pkg::CMD_LOOKUP
               : (r < 84) ? alpht_pkg::CMD_TICK
               : (r < 96) ? alpht_pkg::CMD_FORGET : alpht_pkg::CMD_CLEAR;
        r = $urandom_range(99);
        if (r < 5) it.key = '0;
        else if (r < 15 || key_pool.size() == 0) it.key = {$urandom, $urandom};
        else it.key = key_pool[$urandom_range(key_pool.size() - 1)];
        return it;
    endfunction

    task automatic run_random(int n, int pool_size, bit with_hold);
        key_pool.delete();
        for (int i = 0; i < pool_size; i++) key_pool.push_back({$urandom, $urandom} | 64'd1);
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == 20) hold_start = 1'b1;
            send_item(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        drain_results();
    endtask

    always @(negedge aclk) begin
        if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !((idle_mode == 2 && roll(64)) || (idle_mode == 3 && roll(12)));
        end
    end

    always @(posedge aclk) begin
        alpht_pkg::out_item_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("aging_linear_probe_hash_table verification failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                fails++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status || m_data.slot_index !== want.slot_index
                    || m_data.entry_count !== want.entry_count
                    || m_data.was_cleared !== want.was_cleared) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, m_data);
                    fails++;
                end
            end
        end
    end

    dir_row_t dir_rows[];

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_key[i] = 0;
            tbl_seen[i] = 0;
        end
        tbl_count = 0;
        frame_no = 0;
        idle_cfg = alpht_pkg::IDLE_FRAMES_RST;
        limit_cfg = alpht_pkg::LOAD_LIMIT_RST;
        period_log2 = alpht_pkg::PERIOD_LOG2_RST;
        dir_rows = '{
            '{alpht_pkg::CMD_LOOKUP, 64'd0, 1'b1,
              {alpht_pkg::STAT_NULL, 10'd0, 11'd0, 1'b0}},
            '{alpht_pkg::CMD_FORGET, 64'd0, 1'b1,
              {alpht_pkg::STAT_NULL, 10'd0, 11'd0, 1'b0}},
            '{alpht_pkg::CMD_FORGET, 64'd5, 1'b1,
              {alpht_pkg::STAT_NOT_FOUND, 10'd0, 11'd0, 1'b0}},
            '{alpht_pkg::CMD_TICK, 64'd0, 1'b1,
              {alpht_pkg::STAT_DONE, 10'd0, 11'd0, 1'b0}},
            '{alpht_pkg::CMD_CLEAR, 64'd0, 1'b1,
              {alpht_pkg::STAT_DONE, 10'd0, 11'd0, 1'b0}},
            '{alpht_pkg::CMD_LOOKUP, 64'd1, 1'b0, '0},
            '{alpht_pkg::CMD_LOOKUP, 64'd1, 1'b0, '0},
            '{alpht_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{alpht_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, '0},
            '{alpht_pkg::CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
            '{alpht_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, '0},
            '{alpht_pkg::CMD_FORGET, 64'd1, 1'b0, '0},
            '{alpht_pkg::CMD_FORGET, 64'd1, 1'b0, '0},
            '{alpht_pkg::CMD_TICK, 64'd0, 1'b0, '0},
            '{alpht_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{alpht_pkg::CMD_CLEAR, 64'd0, 1'b1,
              {alpht_pkg::STAT_DONE, 10'd0, 11'd0, 1'b0}},
            '{alpht_pkg::CMD_LOOKUP, 64'd1, 1'b0, '0},
            '{alpht_pkg::CMD_FORGET, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0}
        };
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            send_item('{cmd: dir_rows[i].cmd, key: dir_rows[i].key}, dir_rows[i].typed,
                      dir_rows[i].res);
        end
        s_valid <= 1'b0;
        drain_results();

        cfg_write(4'(4 * alpht_pkg::CFG_IDLE_FRAMES), 32'd0);
        cfg_write(4'(4 * alpht_pkg::CFG_LOAD_LIMIT), 32'd8);
        cfg_write(4'(4 * alpht_pkg::CFG_PERIOD_LOG2), 32'd0);
        run_random(150, 24, 1'b0);

        cfg_write(4'(4 * alpht_pkg::CFG_IDLE_FRAMES), 32'hFFFF_FFFF);
        cfg_write(4'(4 * alpht_pkg::CFG_LOAD_LIMIT), 32'd1023);
        cfg_write(4'(4 * alpht_pkg::CFG_PERIOD_LOG2), 32'd31);
        run_random(400, 40, 1'b0);

        cfg_write(4'(4 * alpht_pkg::CFG_IDLE_FRAMES), 32'd3);
        cfg_write(4'(4 * alpht_pkg::CFG_LOAD_LIMIT), 32'd20);
        cfg_write(4'(4 * alpht_pkg::CFG_PERIOD_LOG2), 32'd2);
        run_random(400, 32, 1'b0);

        cfg_write(4'(4 * alpht_pkg::CFG_LOAD_LIMIT), 32'd0);
        cfg_write(4'(4 * alpht_pkg::CFG_IDLE_FRAMES), 32'd90);
        cfg_write(4'(4 * alpht_pkg::CFG_PERIOD_LOG2), 32'd6);
        run_random(40, 16, 1'b0);

        cfg_write(4'(4 * alpht_pkg::CFG_LOAD_LIMIT), 32'(alpht_pkg::LOAD_LIMIT_RST));
        cfg_write(4'd12, 32'hFFFF_FFFF);
        run_random(500, 48, 1'b1);

        repeat (50) @(negedge aclk);
        if (fails == 0 && expected_results.size() == 0) begin
            $display("aging_linear_probe_hash_table verification clean");
        end else begin
            $display("aging_linear_probe_hash_table verification failed");
        end
        $finish;
    end
endmodule
